// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants, register indexes and helpers for the barometric
// temperature/pressure compensator.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DATA_W   = 32;
    localparam int DIGIT_W  = 4;
    localparam int CNT_W    = 5;
    localparam int PADDR_W  = 6;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_CAL_A = 3'd0;
    localparam t_reg_idx REG_CAL_B = 3'd1;
    localparam t_reg_idx REG_CAL_C = 3'd2;
    localparam t_reg_idx REG_OSS   = 3'd3;
    localparam t_reg_idx REG_PER   = 3'd4;

    localparam logic [7:0]  CMD_TEMP      = 8'h2e;
    localparam logic [7:0]  CMD_PRES_BASE = 8'h34;
    localparam logic [31:0] K_B6_OFS      = 32'd4000;
    localparam logic [31:0] K_P_SQ        = 32'd3038;
    localparam logic [31:0] K_P_LIN       = 32'd7357;
    localparam logic [31:0] K_P_OFS       = 32'd3791;
    localparam logic [31:0] K_B7_SCALE    = 32'd50000;
    localparam logic [31:0] K_B4_OFS      = 32'd32768;
    localparam logic [31:0] K_SIGN       = 32'h80000000;
    localparam logic [31:0] K_P_MAX       = 32'd262143;

    typedef logic [DATA_W-1:0] t_word;

    function automatic t_word asr(input t_word v, input int n);
        asr = t_word'($signed(v) >>> n);
    endfunction

    function automatic t_word sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic t_word mag(input t_word v);
        mag = v[DATA_W-1] ? (t_word'(0) - v) : v;
    endfunction

endpackage

// ----- rtl/bpc_in_if.sv -----
// ----------------------------------------------------------------------------
// bpc_in_if
// Request channel carrying one raw sensor reading.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink   (input valid, input raw_reading, output ready);
endinterface

// ----- rtl/bpc_out_if.sv -----
// ----------------------------------------------------------------------------
// bpc_out_if
// Result channel carrying compensated temperature and pressure.
// ----------------------------------------------------------------------------
interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic               updated_kind;
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic [7:0]         next_command;

    modport source (output valid, output updated_kind, output temperature_tenths,
                    output pressure_pa, output next_command, input ready);
    modport sink   (input valid, input updated_kind, input temperature_tenths,
                    input pressure_pa, input next_command, output ready);
endinterface

// ----- rtl/baro_temp_pressure_compensator.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensator
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// i_req carries one raw 24-bit reading per request; o_rsp returns one result
// per request: the kind updated, last temperature (0.1 degree), last pressure
// (Pa) and the control byte for the next conversion. Calibration, oversampling
// and the temperature period must be written by the user over the APB-style
// port only while idle; the block itself does not enforce this. One request
// is worked on at a time. Every product runs through one 32-bit multiplier
// taking a 4-bit digit per cycle, every quotient through one restoring divider
// taking one quotient bit per cycle. A temperature result needs one product
// and one division, a pressure result ten products plus one division; a zero
// divisor skips the division. The next request can be taken in the cycle
// after the result is loaded, even while that result waits in the output
// register; if the receiver stalls, the next result waits in the sequencer.
// Reset clears the calibration, sets the period to one and restarts with a
// temperature reading; the kept B5 term, temperature and pressure read zero.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensator
    import bpc_pkg::*;
#(
    parameter int PHASE_COUNT_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bpc_in_if.sink             i_req,
    bpc_out_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // temperature steps 0..3, pressure steps 4..15
    localparam logic [3:0] T0 = 4'd0, T1 = 4'd1, T2 = 4'd2, T3 = 4'd3;
    localparam logic [3:0] P0 = 4'd4, P1 = 4'd5, P2 = 4'd6, P3 = 4'd7;
    localparam logic [3:0] P4 = 4'd8, P5 = 4'd9, P6 = 4'd10, P7 = 4'd11;
    localparam logic [3:0] P8 = 4'd12, P9 = 4'd13, P10 = 4'd14, P11 = 4'd15;

    t_state r_state;
    logic [3:0] r_step;
    logic [CNT_W-1:0] r_cnt;

    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    logic [7:0]  r_period;

    logic [PHASE_COUNT_BITS-1:0] r_phase;
    logic [23:0] r_raw;
    logic        r_kind;
    logic [7:0]  r_cmd;
    t_word       r_b5;
    logic [15:0] r_temp;
    logic [17:0] r_pres;

    t_word r_x1, r_b6, r_sq, r_b3, r_b4, r_b7, r_p;
    t_word r_ma, r_mb, r_mr;
    t_word r_dq, r_rem, r_dv, r_q;
    logic  r_neg;

    logic        r_ov;
    logic        r_o_kind;
    logic [15:0] r_o_temp;
    logic [17:0] r_o_pres;
    logic [7:0]  r_o_cmd;

    // calibration words
    t_word ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(r_cal_a[15:0]);
    assign ac2 = sx16(r_cal_a[31:16]);
    assign ac3 = sx16(r_cal_a[47:32]);
    assign ac4 = {16'd0, r_cal_a[63:48]};
    assign ac5 = {16'd0, r_cal_b[15:0]};
    assign ac6 = {16'd0, r_cal_b[31:16]};
    assign b1  = sx16(r_cal_b[47:32]);
    assign b2  = sx16(r_cal_b[63:48]);
    assign mc  = sx16(r_cal_c[15:0]);
    assign md  = sx16(r_cal_c[31:16]);

    // configuration port
    logic     cfg_wr;
    t_reg_idx cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_comb begin
        case (cfg_idx)
            REG_CAL_A: prdata = r_cal_a;
            REG_CAL_B: prdata = r_cal_b;
            REG_CAL_C: prdata = {32'd0, r_cal_c};
            REG_OSS:   prdata = {62'd0, r_oss};
            REG_PER:   prdata = {56'd0, r_period};
            default:   prdata = 64'd0;
        endcase
    end

    // phase decision on request
    logic [7:0] period_eff, pcmd;
    logic       req_take;
    assign period_eff = (r_period == 8'd0) ? 8'd1 : r_period;
    assign pcmd       = CMD_PRES_BASE + {r_oss, 6'd0};
    assign req_take   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // datapath helpers
    t_word up, x3a, x3b, t_raw, p_new, den, div_ge_sub;
    logic [32:0] div_t;
    logic        div_ge;
    assign up    = {8'd0, r_raw} >> (4'd8 - {2'd0, r_oss});
    assign x3a   = r_x1 + asr(r_mr, 11);
    assign x3b   = asr(r_x1 + asr(r_mr, 16) + 32'd2, 2);
    assign t_raw = asr(r_b5 + 32'd8, 4);
    assign p_new = r_p + asr(r_x1 + asr(t_word'(0) - r_mr, 16) + K_P_OFS, 4);
    assign den   = r_x1 + md;
    assign div_t = {r_rem, r_dq[DATA_W-1]};
    assign div_ge = (div_t >= {1'b0, r_dv});
    assign div_ge_sub = t_word'(div_t - {1'b0, r_dv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= T0;
            r_cnt    <= '0;
            r_cal_a  <= '0;
            r_cal_b  <= '0;
            r_cal_c  <= '0;
            r_oss    <= '0;
            r_period <= 8'd1;
            r_phase  <= '0;
            r_b5     <= '0;
            r_temp   <= '0;
            r_pres   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_CAL_A: r_cal_a  <= pwdata;
                    REG_CAL_B: r_cal_b  <= pwdata;
                    REG_CAL_C: r_cal_c  <= pwdata[31:0];
                    REG_OSS:   r_oss    <= pwdata[1:0];
                    REG_PER:   r_period <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_raw   <= i_req.raw_reading;
                        r_state <= S_EXEC;
                        if (r_phase == '0) begin
                            r_kind  <= 1'b0;
                            r_cmd   <= pcmd;
                            r_step  <= T0;
                            r_phase <= PHASE_COUNT_BITS'(1);
                        end else if (16'(r_phase) == 16'(period_eff)) begin
                            r_kind  <= 1'b1;
                            r_cmd   <= CMD_TEMP;
                            r_step  <= P0;
                            r_phase <= '0;
                        end else begin
                            r_kind  <= 1'b1;
                            r_cmd   <= pcmd;
                            r_step  <= P0;
                            r_phase <= r_phase + PHASE_COUNT_BITS'(1);
                        end
                    end
                end
                S_EXEC: begin
                    r_step <= r_step + 4'd1;
                    r_cnt  <= '0;
                    r_mr   <= '0;
                    r_state <= S_MUL;
                    case (r_step)
                        T0: begin
                            r_ma <= {16'd0, r_raw[23:8]} - ac6;
                            r_mb <= ac5;
                        end
                        T1: begin
                            r_x1    <= asr(r_mr, 15);
                            r_state <= S_EXEC;
                        end
                        T2: begin
                            // zero divisor gives all ones
                            if (den == '0) begin
                                r_q     <= '1;
                                r_state <= S_EXEC;
                            end else begin
                                r_dq    <= mag({mc[20:0], 11'd0});
                                r_dv    <= mag(den);
                                r_neg   <= mc[20] ^ den[DATA_W-1];
                                r_rem   <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        T3: begin
                            r_b5    <= r_x1 + r_q;
                            r_state <= S_DONE;
                        end
                        P0: begin
                            r_b6 <= r_b5 - K_B6_OFS;
                            r_ma <= r_b5 - K_B6_OFS;
                            r_mb <= r_b5 - K_B6_OFS;
                        end
                        P1: begin
                            r_sq <= asr(r_mr, 12);
                            r_ma <= b2;
                            r_mb <= asr(r_mr, 12);
                        end
                        P2: begin
                            r_x1 <= asr(r_mr, 11);
                            r_ma <= ac2;
                            r_mb <= r_b6;
                        end
                        P3: begin
                            r_b3 <= asr(((ac1 << 2) + x3a << r_oss) + 32'd2, 2);
                            r_ma <= ac3;
                            r_mb <= r_b6;
                        end
                        P4: begin
                            r_x1 <= asr(r_mr, 13);
                            r_ma <= b1;
                            r_mb <= r_sq;
                        end
                        P5: begin
                            r_ma <= ac4;
                            r_mb <= x3b + K_B4_OFS;
                        end
                        P6: begin
                            r_b4 <= r_mr >> 15;
                            r_ma <= up - r_b3;
                            r_mb <= K_B7_SCALE >> r_oss;
                        end
                        P7: begin
                            r_b7 <= r_mr;
                            if (r_b4 == '0) begin
                                r_q     <= '1;
                                r_state <= S_EXEC;
                            end else begin
                                r_dq    <= (r_mr < K_SIGN) ? (r_mr << 1) : r_mr;
                                r_dv    <= r_b4;
                                r_neg   <= 1'b0;
                                r_rem   <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        P8: begin
                            r_p  <= (r_b7 < K_SIGN) ? r_q : (r_q << 1);
                            r_ma <= asr((r_b7 < K_SIGN) ? r_q : (r_q << 1), 8);
                            r_mb <= asr((r_b7 < K_SIGN) ? r_q : (r_q << 1), 8);
                        end
                        P9: begin
                            r_ma <= r_mr;
                            r_mb <= K_P_SQ;
                        end
                        P10: begin
                            r_x1 <= asr(r_mr, 16);
                            r_ma <= r_p;
                            r_mb <= K_P_LIN;
                        end
                        P11: begin
                            if (p_new[DATA_W-1]) begin
                                r_pres <= '0;
                            end else if (p_new > K_P_MAX) begin
                                r_pres <= '1;
                            end else begin
                                r_pres <= p_new[17:0];
                            end
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MUL: begin
                    // one 4-bit digit of the multiplier per cycle
                    r_mr  <= r_mr + r_ma * {28'd0, r_mb[DIGIT_W-1:0]};
                    r_ma  <= r_ma << DIGIT_W;
                    r_mb  <= r_mb >> DIGIT_W;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_W / DIGIT_W - 1)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_ge_sub : div_t[DATA_W-1:0];
                    r_dq  <= {r_dq[DATA_W-2:0], div_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_q <= r_neg ? (t_word'(0) - {r_dq[DATA_W-2:0], div_ge})
                                     : {r_dq[DATA_W-2:0], div_ge};
                        r_state <= S_EXEC;
                    end
                end
                S_DONE: begin
                    if (!r_kind) begin
                        if ($signed(t_raw) > 32'sd32767) begin
                            r_temp <= 16'h7fff;
                        end else if ($signed(t_raw) < -32'sd32768) begin
                            r_temp <= 16'h8000;
                        end else begin
                            r_temp <= t_raw[15:0];
                        end
                    end
                    r_state <= S_DONE;
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register, temperature saturated in the same cycle it is loaded
    logic [15:0] temp_out;
    always_comb begin
        if (r_kind) begin
            temp_out = r_temp;
        end else if ($signed(t_raw) > 32'sd32767) begin
            temp_out = 16'h7fff;
        end else if ($signed(t_raw) < -32'sd32768) begin
            temp_out = 16'h8000;
        end else begin
            temp_out = t_raw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ov || o_rsp.ready)) begin
            r_o_kind <= r_kind;
            r_o_temp <= temp_out;
            r_o_pres <= r_pres;
            r_o_cmd  <= r_cmd;
        end
    end

    assign o_rsp.valid              = r_ov;
    assign o_rsp.updated_kind       = r_o_kind;
    assign o_rsp.temperature_tenths = r_o_temp;
    assign o_rsp.pressure_pa        = r_o_pres;
    assign o_rsp.next_command       = r_o_cmd;

endmodule

// ----- tb/tb_baro_temp_pressure_compensator.sv -----
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensator
// Self-checking bench for the barometric compensator: calibration is written
// over the register port while idle, raw readings are pushed with random gaps
// and the receiver stalls at random. A scoreboard predicts every result and
// compares it field by field.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensator
    import bpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct {
        logic        kind;
        logic [15:0] temp;
        logic [17:0] pres;
        logic [7:0]  cmd;
    } t_comp_result;

    class t_comp_scoreboard;
        logic [63:0]  cal_a, cal_b;
        logic [31:0]  cal_c;
        logic [1:0]   oss;
        logic [7:0]   period;
        logic [7:0]   phase;
        logic [31:0]  b5;
        logic [15:0]  temp_last;
        logic [17:0]  pres_last;
        t_comp_result pending[$];
        int           failures;

        function new();
            cal_a = '0; cal_b = '0; cal_c = '0; oss = '0; period = 8'd1;
            phase = '0; b5 = '0; temp_last = '0; pres_last = '0; failures = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] val);
            case (idx)
                REG_CAL_A: cal_a = val;
                REG_CAL_B: cal_b = val;
                REG_CAL_C: cal_c = val[31:0];
                REG_OSS:   oss = val[1:0];
                REG_PER:   period = val[7:0];
                default: ;
            endcase
        endfunction

        static function logic [31:0] sra(logic [31:0] v, int n);
            return $unsigned($signed(v) >>> n);
        endfunction

        static function logic [31:0] sext(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function void calc_temp_reading(logic [23:0] raw);
            logic [31:0] ac5, ac6, mc, md, ut, x1, den, x2, m2;
            longint      t;
            ac5 = {16'd0, cal_b[15:0]};
            ac6 = {16'd0, cal_b[31:16]};
            mc  = sext(cal_c[15:0]);
            md  = sext(cal_c[31:16]);
            ut  = {16'd0, raw[23:8]};
            x1  = sra((ut - ac6) * ac5, 15);
            den = x1 + md;
            m2  = mc * 32'd2048;
            if (den == 0)
                x2 = '1;
            else
                x2 = 32'(longint'($signed(m2)) / longint'($signed(den)));
            b5 = x1 + x2;
            t = longint'($signed(sra(b5 + 32'd8, 4)));
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            temp_last = t[15:0];
        endfunction

        function void calc_pres_reading(logic [23:0] raw);
            logic [31:0] ac1, ac2, ac3, ac4, b1, b2, up, b6, sq;
            logic [31:0] x1, x2, x3, b3, b4, b7, p;
            longint      ps;
            ac1 = sext(cal_a[15:0]);
            ac2 = sext(cal_a[31:16]);
            ac3 = sext(cal_a[47:32]);
            ac4 = {16'd0, cal_a[63:48]};
            b1  = sext(cal_b[47:32]);
            b2  = sext(cal_b[63:48]);
            up  = {8'd0, raw} >> (8 - oss);
            b6  = b5 - 32'd4000;
            sq  = sra(b6 * b6, 12);
            x1  = sra(b2 * sq, 11);
            x2  = sra(ac2 * b6, 11);
            x3  = x1 + x2;
            b3  = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
            x1  = sra(ac3 * b6, 13);
            x2  = sra(b1 * sq, 16);
            x3  = sra(x1 + x2 + 32'd2, 2);
            b4  = (ac4 * (x3 + 32'd32768)) >> 15;
            b7  = (up - b3) * (32'd50000 >> oss);
            if (!b7[31])
                p = (b4 == 0) ? '1 : (b7 << 1) / b4;
            else
                p = ((b4 == 0) ? '1 : b7 / b4) << 1;
            x1 = sra(p, 8) * sra(p, 8);
            x1 = sra(x1 * 32'd3038, 16);
            x2 = sra(32'd0 - 32'd7357 * p, 16);
            p  = p + sra(x1 + x2 + 32'd3791, 4);
            ps = longint'($signed(p));
            if (ps < 0) ps = 0;
            if (ps > 262143) ps = 262143;
            pres_last = ps[17:0];
        endfunction

        function void note_request(logic [23:0] raw);
            t_comp_result r;
            logic [7:0]   per, pcmd;
            per  = (period == 0) ? 8'd1 : period;
            pcmd = CMD_PRES_BASE + {oss, 6'd0};
            if (phase == 0) begin
                calc_temp_reading(raw);
                r.kind = 1'b0; r.cmd = pcmd; phase = 8'd1;
            end else if (phase == per) begin
                calc_pres_reading(raw);
                r.kind = 1'b1; r.cmd = CMD_TEMP; phase = 8'd0;
            end else begin
                calc_pres_reading(raw);
                r.kind = 1'b1; r.cmd = pcmd; phase = phase + 8'd1;
            end
            r.temp = temp_last;
            r.pres = pres_last;
            pending.push_back(r);
        endfunction

        function void check_result(logic kind, logic [15:0] temp, logic [17:0] pres,
                                   logic [7:0] cmd);
            t_comp_result e;
            if (pending.size() == 0) begin
                $error("unexpected result: kind %0d temp %0d pres %0d cmd %0h",
                       kind, $signed(temp), pres, cmd);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $error("updated_kind: expected %0d, got %0d", e.kind, kind);
                failures++;
            end
            if (temp !== e.temp) begin
                $error("temperature_tenths: expected %0d, got %0d",
                       $signed(e.temp), $signed(temp));
                failures++;
            end
            if (pres !== e.pres) begin
                $error("pressure_pa: expected %0d, got %0d", e.pres, pres);
                failures++;
            end
            if (cmd !== e.cmd) begin
                $error("next_command: expected %0h, got %0h", e.cmd, cmd);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    int                 idle_cycles = 0;
    int                 rx_hold = 0;
    bit                 rx_bursty = 1'b0;

    bpc_in_if  req_if ();
    bpc_out_if rsp_if ();

    t_comp_scoreboard sb = new();

    baro_temp_pressure_compensator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_if.valid       = 1'b0;
        req_if.raw_reading = '0;
        rsp_if.ready       = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, a few long, check every accepted result
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.updated_kind, rsp_if.temperature_tenths,
                            rsp_if.pressure_pa, rsp_if.next_command);
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_hold      <= 0;
        end else if (!rx_bursty) begin
            rsp_if.ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            rsp_if.ready <= 1'b0;
            rx_hold      <= $urandom_range(10, 80);
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) < 65);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_reading(logic [23:0] raw, int gap);
        req_if.valid       <= 1'b1;
        req_if.raw_reading <= raw;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(raw);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(logic [63:0] ca, logic [63:0] cb, logic [31:0] cc,
                               logic [1:0] os, logic [7:0] per);
        write_reg(REG_CAL_A, ca);
        write_reg(REG_CAL_B, cb);
        write_reg(REG_CAL_C, {32'd0, cc});
        write_reg(REG_OSS, {62'd0, os});
        write_reg(REG_PER, {56'd0, per});
    endtask

    // typical sensor calibration, with optional jitter on each word
    function automatic logic [63:0] jit(logic [15:0] w3, logic [15:0] w2,
                                        logic [15:0] w1, logic [15:0] w0, bit on);
        logic [15:0] d [4];
        for (int k = 0; k < 4; k++)
            d[k] = on ? 16'($signed($urandom_range(0, 400)) - 200) : 16'd0;
        return {w3 + d[3], w2 + d[2], w1 + d[1], w0 + d[0]};
    endfunction

    function automatic logic [23:0] pick_raw(bit realistic);
        if (realistic && $urandom_range(0, 1))
            return 24'($urandom_range(20000, 40000)) << 8 | 24'($urandom_range(0, 255));
        if (realistic)
            return 24'($urandom_range(15000, 30000)) << 8 | 24'($urandom_range(0, 255));
        return 24'($urandom);
    endfunction

    initial begin
        logic [63:0] ca, cb;
        logic [31:0] cc;
        logic [7:0]  per;
        bit          real_cal;
        logic [23:0] directed_raw [8];

        directed_raw = '{24'h000000, 24'hffffff, 24'h800000, 24'h7fffff,
                         24'h6cfa00, 24'h5d2300, 24'h00ff00, 24'hff00ff};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: every divisor is zero
        foreach (directed_raw[k]) send_reading(directed_raw[k], 0);
        drain();

        // datasheet calibration, every oversampling setting
        rx_bursty = 1'b1;
        for (int os = 0; os < 4; os++) begin
            load_config({16'd32741, 16'($signed(-14383)), 16'($signed(-72)), 16'd408},
                        {16'd4, 16'd6190, 16'd23153, 16'd32757},
                        {16'd2868, 16'($signed(-8711))}, 2'(os), 8'(os + 1));
            for (int k = 0; k < 4; k++) send_reading(directed_raw[(os * 2 + k) % 8], 0);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            real_cal = (ph % 3) != 2;
            if (real_cal) begin
                ca = jit(16'd32741, 16'($signed(-14383)), 16'($signed(-72)), 16'd408, 1);
                cb = jit(16'd4, 16'd6190, 16'd23153, 16'd32757, 1);
                cc = {16'd2868 + 16'($urandom_range(0, 200)), 16'($signed(-8711))};
            end else if (ph == 2) begin
                ca = '1; cb = '1; cc = '1;
            end else begin
                ca = {$urandom, $urandom};
                cb = {$urandom, $urandom};
                cc = $urandom;
            end
            case (ph)
                0: per = 8'd1;
                1: per = 8'd255;
                2: per = 8'd2;
                default: per = 8'($urandom_range(1, 12));
            endcase
            load_config(ca, cb, cc, 2'($urandom_range(0, 3)), per);
            rx_bursty = (ph % 4) != 3;
            for (int n = 0; n < 115; n++) begin
                // sender hold-off until the block has caught up
                if (n == 60) begin
                    req_if.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                send_reading(pick_raw(real_cal && $urandom_range(0, 3) != 0),
                             (ph % 4 == 3) ? 0 : pick_gap());
            end
            drain();
        end

        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
